@@ rtl/core/http_request_line_parser_unit_macros.svh @@
// Assertion macros used by the parser RTL.
`ifndef HTTP_REQUEST_LINE_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define HRLP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrlp assertion failed");

// Check that cons holds in the cycle after ante.
`define HRLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrlp assertion failed");

`endif

@@ rtl/core/hrlp_pkg.sv @@
package hrlp_pkg;

    localparam int LINE_BYTES_MAX = 4096;
    localparam int LEN_W          = 12;
    localparam int POS_W          = 13;
    localparam int CFG_W          = 13;
    localparam int BYTE_W         = 8;

    localparam logic [CFG_W-1:0]  MAX_LINE_RESET = CFG_W'(1000);
    localparam logic [POS_W-1:0]  VERSION_OFFSET = POS_W'(6);

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_TOO_LONG = 1'b1;

    typedef struct packed {
        logic              status;
        logic [LEN_W-1:0]  method_length;
        logic [LEN_W-1:0]  target_start;
        logic [LEN_W-1:0]  target_length;
        logic              has_query;
        logic [LEN_W-1:0]  query_start;
        logic [LEN_W-1:0]  query_length;
        logic [BYTE_W-1:0] version_digit;
        logic              version_valid;
    } t_result;

endpackage

@@ rtl/core/hrlp_in_reg.sv @@
module hrlp_in_reg
    import hrlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_start_of_request,
    input  logic              i_advance,
    output logic              o_step,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_start_of_request
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;
    logic              r_sor;

    // Take a new word when the register is empty or the held one moves on this cycle.
    assign o_ready            = !r_valid || i_advance;
    assign o_step             = r_valid && i_advance;
    assign o_data_byte        = r_data;
    assign o_start_of_request = r_sor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data_byte;
            r_sor  <= i_start_of_request;
        end
    end

endmodule

@@ rtl/core/hrlp_parse.sv @@
`include "http_request_line_parser_unit_macros.svh"

module hrlp_parse
    import hrlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_start_of_request,
    output logic              o_res_valid,
    output t_result           o_res
);

    typedef enum logic [2:0] {
        PH_METHOD = 3'd0,
        PH_TARGET = 3'd1,
        PH_QUERY  = 3'd2,
        PH_TAIL   = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    logic [CFG_W-1:0]  r_max_line;
    t_phase            r_phase,       n_phase,       e_phase;
    logic [POS_W-1:0]  r_pos,         n_pos,         e_pos;
    logic [LEN_W-1:0]  r_method_mark, n_method_mark, e_method_mark;
    logic [LEN_W-1:0]  r_path_mark,   n_path_mark,   e_path_mark;
    logic [LEN_W-1:0]  r_query_mark,  n_query_mark,  e_query_mark;
    logic [BYTE_W-1:0] r_prev,        n_prev,        e_prev;
    logic [BYTE_W-1:0] r_ver,         n_ver,         e_ver;
    logic              r_ver_seen,    n_ver_seen,    e_ver_seen;
    logic              r_qry_seen,    n_qry_seen,    e_qry_seen;
    logic [POS_W-1:0]  limit;
    logic [LEN_W-1:0]  pos_l;
    logic              line_end;

    always_comb begin
        limit = (r_max_line > CFG_W'(LINE_BYTES_MAX)) ? POS_W'(LINE_BYTES_MAX)
                                                      : POS_W'(r_max_line);
    end

    // Start of request: clear the line before this byte is parsed.
    always_comb begin
        if (i_start_of_request) begin
            e_phase       = PH_METHOD;
            e_pos         = '0;
            e_method_mark = '0;
            e_path_mark   = '0;
            e_query_mark  = '0;
            e_prev        = '0;
            e_ver         = '0;
            e_ver_seen    = 1'b0;
            e_qry_seen    = 1'b0;
        end else begin
            e_phase       = r_phase;
            e_pos         = r_pos;
            e_method_mark = r_method_mark;
            e_path_mark   = r_path_mark;
            e_query_mark  = r_query_mark;
            e_prev        = r_prev;
            e_ver         = r_ver;
            e_ver_seen    = r_ver_seen;
            e_qry_seen    = r_qry_seen;
        end
    end

    always_comb begin
        n_phase       = e_phase;
        n_pos         = e_pos;
        n_method_mark = e_method_mark;
        n_path_mark   = e_path_mark;
        n_query_mark  = e_query_mark;
        n_prev        = e_prev;
        n_ver         = e_ver;
        n_ver_seen    = e_ver_seen;
        n_qry_seen    = e_qry_seen;
        o_res_valid   = 1'b0;
        o_res         = '0;
        line_end      = 1'b0;
        pos_l         = e_pos[LEN_W-1:0];

        if (e_phase == PH_METHOD || e_phase == PH_TARGET ||
            e_phase == PH_QUERY  || e_phase == PH_TAIL) begin
            if (e_pos >= limit) begin
                o_res_valid  = 1'b1;
                o_res.status = STATUS_TOO_LONG;
                n_phase      = PH_DONE;
            end else begin
                case (e_phase)
                    PH_METHOD: begin
                        if (i_data_byte == CH_SPACE) begin
                            n_method_mark = pos_l;
                            n_phase       = PH_TARGET;
                        end
                    end
                    PH_TARGET: begin
                        if (i_data_byte == CH_QMARK) begin
                            n_path_mark = pos_l;
                            n_qry_seen  = 1'b1;
                            n_phase     = PH_QUERY;
                        end else if (i_data_byte == CH_SPACE) begin
                            n_path_mark  = pos_l;
                            n_query_mark = pos_l;
                            n_phase      = PH_TAIL;
                        end
                    end
                    PH_QUERY: begin
                        if (i_data_byte == CH_SPACE) begin
                            n_query_mark = pos_l;
                            n_phase      = PH_TAIL;
                        end
                    end
                    default: begin
                        if (e_pos == (POS_W'(e_query_mark) + VERSION_OFFSET)) begin
                            n_ver      = i_data_byte - CH_ZERO;
                            n_ver_seen = 1'b1;
                        end
                        if (i_data_byte == CH_LF && e_prev == CH_CR) begin
                            line_end            = 1'b1;
                            o_res_valid         = 1'b1;
                            o_res.status        = STATUS_OK;
                            o_res.method_length = e_method_mark;
                            o_res.target_start  = e_method_mark + LEN_W'(1);
                            o_res.target_length = e_path_mark - e_method_mark - LEN_W'(1);
                            o_res.has_query     = e_qry_seen;
                            if (e_qry_seen) begin
                                o_res.query_start  = e_path_mark + LEN_W'(1);
                                o_res.query_length = e_query_mark - e_path_mark - LEN_W'(1);
                            end
                            o_res.version_digit = n_ver_seen ? n_ver : '0;
                            o_res.version_valid = n_ver_seen;
                            n_phase             = PH_DONE;
                        end
                    end
                endcase
                if (!line_end) begin
                    n_prev = i_data_byte;
                    n_pos  = e_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line <= MAX_LINE_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_line <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_METHOD;
            r_pos         <= '0;
            r_method_mark <= '0;
            r_path_mark   <= '0;
            r_query_mark  <= '0;
            r_prev        <= '0;
            r_ver         <= '0;
            r_ver_seen    <= 1'b0;
            r_qry_seen    <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_method_mark <= n_method_mark;
            r_path_mark   <= n_path_mark;
            r_query_mark  <= n_query_mark;
            r_prev        <= n_prev;
            r_ver         <= n_ver;
            r_ver_seen    <= n_ver_seen;
            r_qry_seen    <= n_qry_seen;
        end
    end

    `HRLP_ASSERT_NEXT(a_done_after_result, i_clk, i_rst_n, i_step && o_res_valid, r_phase == PH_DONE)
    `HRLP_ASSERT_SAME(a_too_long_clean, i_clk, i_rst_n, o_res_valid && o_res.status, o_res.method_length == '0 && o_res.has_query == 1'b0 && o_res.version_valid == 1'b0)
    `HRLP_ASSERT_SAME(a_pos_bounded, i_clk, i_rst_n, 1'b1, r_pos <= POS_W'(LINE_BYTES_MAX))
    `HRLP_ASSERT_SAME(a_no_query_zero, i_clk, i_rst_n, o_res_valid && !o_res.has_query, o_res.query_start == '0 && o_res.query_length == '0)

endmodule

@@ rtl/core/hrlp_out_reg.sv @@
module hrlp_out_reg
    import hrlp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Move on when the result slot is empty or being drained.
    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_step && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_step && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

@@ rtl/core/http_request_line_parser_unit.sv @@
// A byte that finishes a line is parsed from the input register; its result is
// registered in the output register on the edge at which that byte steps.
// Throughput: 1 byte per cycle while results are taken; the parse state updates
// in one pass per byte. While a result waits to be taken, one more byte fits in
// the input register, then o_ready stays low until the result is taken.
// Reset (i_rst_n low, synchronous): empties both registers, sets the line limit
// to 1000 bytes and starts parsing at position 0 in the method phase.
module http_request_line_parser_unit
    import hrlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: line length limit
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    // byte stream in
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_start_of_request,
    // result out
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_status,
    output logic [LEN_W-1:0]  o_method_length,
    output logic [LEN_W-1:0]  o_target_start,
    output logic [LEN_W-1:0]  o_target_length,
    output logic              o_has_query,
    output logic [LEN_W-1:0]  o_query_start,
    output logic [LEN_W-1:0]  o_query_length,
    output logic [BYTE_W-1:0] o_version_digit,
    output logic              o_version_valid
);

    // Pipeline handshake: the output side grants advance, the input
    // register turns it into a parse step when it holds a word.
    logic              advance;
    logic              step;
    logic [BYTE_W-1:0] step_byte;
    logic              step_sor;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    hrlp_in_reg u_in_reg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_byte        (i_data_byte),
        .i_start_of_request (i_start_of_request),
        .i_advance          (advance),
        .o_step             (step),
        .o_data_byte        (step_byte),
        .o_start_of_request (step_sor)
    );

    // Parse one byte per step: phase tracking, positions and result build.
    hrlp_parse u_parse (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_step             (step),
        .i_data_byte        (step_byte),
        .i_start_of_request (step_sor),
        .o_res_valid        (res_valid),
        .o_res              (res)
    );

    // Hold the finished result until the consumer takes it.
    hrlp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (i_ready),
        .o_advance   (advance),
        .o_valid     (o_valid),
        .o_res       (out_res)
    );

    assign o_status        = out_res.status;
    assign o_method_length = out_res.method_length;
    assign o_target_start  = out_res.target_start;
    assign o_target_length = out_res.target_length;
    assign o_has_query     = out_res.has_query;
    assign o_query_start   = out_res.query_start;
    assign o_query_length  = out_res.query_length;
    assign o_version_digit = out_res.version_digit;
    assign o_version_valid = out_res.version_valid;

endmodule

@@ tb/tb_http_request_line_parser_unit.sv @@
`timescale 1ns / 100ps

import hrlp_pkg::*;

typedef enum logic [2:0] {
    LP_METHOD,
    LP_TARGET,
    LP_QUERY,
    LP_TAIL,
    LP_DONE
} line_phase_e;

// Tracks the parse of the request line, holds the line reports still owed by
// the block and checks each one that comes out.
class line_scoreboard;
    t_result          expected_q[$];
    int unsigned      mismatches;
    logic [CFG_W-1:0] line_limit;
    line_phase_e      phase;
    int unsigned      position;
    int unsigned      method_mark;
    int unsigned      path_mark;
    int unsigned      query_mark;
    logic [7:0]       prev_byte;
    logic [7:0]       version_byte;
    bit               version_hit;
    bit               query_hit;

    function new();
        mismatches = 0;
        line_limit = MAX_LINE_RESET;
        clear_line();
    endfunction

    function void clear_line();
        phase        = LP_METHOD;
        position     = 0;
        method_mark  = 0;
        path_mark    = 0;
        query_mark   = 0;
        prev_byte    = '0;
        version_byte = '0;
        version_hit  = 1'b0;
        query_hit    = 1'b0;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // Advance the parse by one accepted word; returns 0 when the byte is ignored.
    function bit note_byte(logic [7:0] b, logic sof);
        int unsigned limit;
        t_result     res;
        if (sof)
            clear_line();
        if (phase == LP_DONE)
            return 1'b0;
        limit = (line_limit > LINE_BYTES_MAX) ? LINE_BYTES_MAX : line_limit;
        if (position >= limit) begin
            res = '0;
            res.status = STATUS_TOO_LONG;
            expected_q.push_back(res);
            phase = LP_DONE;
            return 1'b1;
        end
        case (phase)
            LP_METHOD: begin
                if (b == CH_SPACE) begin
                    method_mark = position;
                    phase = LP_TARGET;
                end
            end
            LP_TARGET: begin
                if (b == CH_SPACE || b == CH_QMARK) begin
                    path_mark = position;
                    if (b == CH_QMARK) begin
                        query_hit = 1'b1;
                        phase = LP_QUERY;
                    end else begin
                        query_mark = position;
                        phase = LP_TAIL;
                    end
                end
            end
            LP_QUERY: begin
                if (b == CH_SPACE) begin
                    query_mark = position;
                    phase = LP_TAIL;
                end
            end
            default: begin
                if (position == query_mark + VERSION_OFFSET) begin
                    version_byte = b - CH_ZERO;
                    version_hit = 1'b1;
                end
                if (b == CH_LF && prev_byte == CH_CR) begin
                    res = '0;
                    res.status        = STATUS_OK;
                    res.method_length = LEN_W'(method_mark);
                    res.target_start  = LEN_W'(method_mark + 1);
                    res.target_length = LEN_W'(path_mark - method_mark - 1);
                    res.has_query     = query_hit;
                    if (query_hit) begin
                        res.query_start  = LEN_W'(path_mark + 1);
                        res.query_length = LEN_W'(query_mark - path_mark - 1);
                    end
                    res.version_digit = version_hit ? version_byte : '0;
                    res.version_valid = version_hit;
                    expected_q.push_back(res);
                    phase = LP_DONE;
                    return 1'b1;
                end
            end
        endcase
        prev_byte = b;
        position = position + 1;
        return 1'b1;
    endfunction

    task report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_result(t_result got);
        t_result want;
        if (expected_q.size() == 0) begin
            report_mismatch("result word with no line report pending");
            return;
        end
        want = expected_q.pop_front();
        compare_field("status", got.status, want.status);
        compare_field("method_length", got.method_length, want.method_length);
        compare_field("target_start", got.target_start, want.target_start);
        compare_field("target_length", got.target_length, want.target_length);
        compare_field("has_query", got.has_query, want.has_query);
        compare_field("query_start", got.query_start, want.query_start);
        compare_field("query_length", got.query_length, want.query_length);
        compare_field("version_digit", got.version_digit, want.version_digit);
        compare_field("version_valid", got.version_valid, want.version_valid);
    endtask
endclass

module tb_http_request_line_parser_unit;

    // Generous ceiling for the watchdog.
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    // Cycles to let a byte that gives no report clear the pipeline.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned GAP_MAX       = 14;

    logic              i_clk              = 1'b0;
    logic              i_rst_n            = 1'b0;
    logic              i_cfg_wr_en        = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wr_data      = '0;
    logic              i_valid            = 1'b0;
    logic              o_ready;
    logic [BYTE_W-1:0] i_data_byte        = '0;
    logic              i_start_of_request = 1'b0;
    logic              o_valid;
    logic              i_ready            = 1'b0;
    logic              o_status;
    logic [LEN_W-1:0]  o_method_length;
    logic [LEN_W-1:0]  o_target_start;
    logic [LEN_W-1:0]  o_target_length;
    logic              o_has_query;
    logic [LEN_W-1:0]  o_query_start;
    logic [LEN_W-1:0]  o_query_length;
    logic [BYTE_W-1:0] o_version_digit;
    logic              o_version_valid;

    line_scoreboard    sb;
    logic [7:0]        line_bytes[$];
    int unsigned       parsed_bytes  = 0;
    int unsigned       cycle_count   = 0;
    int unsigned       rx_hold_cycles = 0;
    bit                tx_burst      = 1'b0;
    bit                rx_burst      = 1'b0;

    http_request_line_parser_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_byte        (i_data_byte),
        .i_start_of_request (i_start_of_request),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_method_length    (o_method_length),
        .o_target_start     (o_target_start),
        .o_target_length    (o_target_length),
        .o_has_query        (o_has_query),
        .o_query_start      (o_query_start),
        .o_query_length     (o_query_length),
        .o_version_digit    (o_version_digit),
        .o_version_valid    (o_version_valid)
    );

    always #6 i_clk = ~i_clk;

    // Hold reset at the start, then release it for good.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Watchdog: end the run as failed once the cycle count reaches CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one word and hold it, unchanged, until the block takes it. The
    // idle gap comes before raising valid, so back-to-back words keep valid
    // high across the edge without a second assignment in the same step.
    task automatic send_byte(input logic [7:0] b, input logic sof);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_data_byte        <= b;
        i_start_of_request <= sof;
        do @(posedge i_clk); while (!o_ready);
        parsed_bytes += sb.note_byte(b, sof);
    endtask

    // Push the staged line into the block; mark the first word as a start if asked.
    task automatic send_line(input bit with_start);
        foreach (line_bytes[i])
            send_byte(line_bytes[i], with_start && (i == 0));
        line_bytes.delete();
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endfunction

    // Printable byte that neither ends the target nor opens a query.
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7E));
        return (c == CH_QMARK) ? 8'h2F : c;
    endfunction

    // Drop valid and pause the sender until every owed report has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the line limit while the block is idle.
    task automatic set_line_limit(input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.line_limit = value;
    endtask

    // Mostly well-formed lines with random content; the rest are broken lines
    // full of delimiters and bare noise words.
    task automatic send_random_line();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 15) == 0)
            tx_burst = !tx_burst;
        if (kind <= 6) begin
            n = $urandom_range(0, 6);
            repeat (n) line_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
            line_bytes.push_back(CH_SPACE);
            if ($urandom_range(0, 5) != 0)
                line_bytes.push_back(8'h2F);
            n = $urandom_range(0, 6);
            repeat (n) line_bytes.push_back(text_char());
            if ($urandom_range(0, 1)) begin
                line_bytes.push_back(CH_QMARK);
                n = $urandom_range(0, 6);
                repeat (n)
                    line_bytes.push_back(($urandom_range(0, 4) == 0) ? CH_QMARK : text_char());
            end
            line_bytes.push_back(CH_SPACE);
            case ($urandom_range(0, 3))
                0: add_text("HTTP/1.1");
                1: add_text("HTTP/2");
                2: begin
                    n = $urandom_range(0, 9);
                    repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    add_text("HTTP/");
                    line_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
                end
            endcase
            line_bytes.push_back(CH_CR);
            line_bytes.push_back(CH_LF);
            send_line(1'b1);
        end else if (kind <= 8) begin
            n = $urandom_range(1, 14);
            repeat (n) begin
                case ($urandom_range(0, 5))
                    0: line_bytes.push_back(CH_SPACE);
                    1: line_bytes.push_back(CH_QMARK);
                    2: line_bytes.push_back(CH_CR);
                    3: line_bytes.push_back(CH_LF);
                    default: line_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            send_line(1'($urandom_range(0, 1)));
        end else begin
            n = $urandom_range(1, 5);
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random_lines(input int unsigned count);
        int unsigned target;
        target = parsed_bytes + count;
        while (parsed_bytes < target) send_random_line();
    endtask

    // Result side: stall a random number of cycles before each word, or for a
    // long stretch when the sender asks for back pressure.
    initial begin
        int unsigned stall;
        t_result     got;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got = {o_status, o_method_length, o_target_start, o_target_length, o_has_query,
                   o_query_start, o_query_length, o_version_digit, o_version_valid};
            sb.check_result(got);
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
        end
    end

    // Stimulus.
    initial begin
        sb = new();
        wait (i_rst_n);
        @(posedge i_clk);

        // First line straight out of reset, no start flag; has a query.
        add_text("G /?a H\r\n");
        send_line(1'b0);
        // Version byte lands on the final LF.
        add_text("M  abcd\r\n");
        send_line(1'b1);
        // Drop everything after a finished line until the next start.
        add_text("x\r\n");
        send_line(1'b0);
        // Byte extremes inside the method.
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        add_text(" /x \r\n");
        send_line(1'b1);

        run_random_lines(180);

        // Register above the hard cap: the cap rules.
        set_line_limit(CFG_W'(8191));
        run_random_lines(60);

        // Limit exactly at the cap.
        set_line_limit(CFG_W'(LINE_BYTES_MAX));
        run_random_lines(60);

        // Limit of zero: every line ends on its first byte.
        set_line_limit('0);
        send_byte(8'h47, 1'b1);
        send_byte(8'h47, 1'b0);
        send_byte(CH_SPACE, 1'b1);
        run_random_lines(8);

        // Smallest legal limit.
        set_line_limit(CFG_W'(1));
        run_random_lines(16);

        // Short random limit: overflows mixed with complete lines.
        set_line_limit(CFG_W'($urandom_range(8, 48)));
        run_random_lines(100);

        // Back pressure: hold off results while the sender keeps offering
        // short lines, so the result path fills and the input stalls.
        set_line_limit(MAX_LINE_RESET);
        tx_burst = 1'b1;
        rx_hold_cycles = 400;
        repeat (40) begin
            add_text("G / \r\n");
            send_line(1'b1);
        end
        tx_burst = 1'b0;
        drain_results();
        run_random_lines(120);

        drain_results();
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/hrlp_pkg.sv
rtl/core/hrlp_in_reg.sv
rtl/core/hrlp_parse.sv
rtl/core/hrlp_out_reg.sv
rtl/core/http_request_line_parser_unit.sv
tb/tb_http_request_line_parser_unit.sv
